>>> rtl/swec_pkg.sv
package swec_pkg;

  // Field widths of the item payloads
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned BUCKET_W = 32;
  localparam int unsigned TOTAL_W  = 38;

  // Default ring size
  localparam int unsigned NUM_BUCKETS_DEF = 64;

  typedef struct packed {
    logic [TIME_W-1:0]  time_sec;
    logic [COUNT_W-1:0] add_count;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] window_total;
    logic               rejected;
  } out_item_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SAME,
    ST_CLASS,
    ST_PLAN,
    ST_SKIP,
    ST_TGT,
    ST_ADD,
    ST_CLEAR,
    ST_PUT,
    ST_DONE
  } state_t;

endpackage

>>> rtl/swec_ram.sv
module swec_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/sliding_window_event_counter_unit.sv
// Per-second sliding-window event counter. Each input item carries a time in
// seconds and an event count; the result item gives the window total after the
// update, or the unchanged total with rejected set when time went backwards.
// Buckets live in one synchronous RAM of NUM_BUCKETS words, read-modify-write.
// An item in the same second as the last one is handled by a read, then an
// update and write back. A forward step of g seconds with g < NUM_BUCKETS
// does one RAM read and write per skipped bucket before the target bucket.
// A step of NUM_BUCKETS or more runs a sweep that zeroes the RAM while the
// target slot is worked out by reciprocal multiplication at its start:
// quotient estimate, remainder estimate, then correction.
// A backwards time goes straight from classification to the result. After
// reset the RAM is cleared by the same sweep, during which in_ready stays
// low. A finished result sits in an output register so the next item can be
// taken while it waits.
module sliding_window_event_counter_unit #(
  parameter int unsigned NUM_BUCKETS = swec_pkg::NUM_BUCKETS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  swec_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output swec_pkg::out_item_t out_item
);

  import swec_pkg::*;

  localparam int unsigned SLOT_W    = $clog2(NUM_BUCKETS);
  localparam int unsigned CLEAR_LEN = (NUM_BUCKETS > 4) ? NUM_BUCKETS : 4;
  localparam int unsigned STEP_W    = $clog2(CLEAR_LEN);
  localparam int unsigned RECIP_SH  = TIME_W - 1 + SLOT_W;

  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(NUM_BUCKETS - 1);
  localparam logic [SLOT_W:0]    SLOT_N    = (SLOT_W+1)'(NUM_BUCKETS);
  localparam logic [STEP_W:0]    STEP_N    = (STEP_W+1)'(NUM_BUCKETS);
  localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(CLEAR_LEN - 1);
  localparam logic [TIME_W-1:0]  TIME_N    = TIME_W'(NUM_BUCKETS);
  localparam logic [TIME_W-1:0]  RECIP     =
    TIME_W'((64'd1 << RECIP_SH) / 64'(NUM_BUCKETS));
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Saturating total arithmetic
  function automatic logic [TOTAL_W-1:0] total_add(
    input logic [TOTAL_W-1:0]  a,
    input logic [BUCKET_W-1:0] b
  );
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + (TOTAL_W+1)'(b);
    return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] total_sub(
    input logic [TOTAL_W-1:0]  a,
    input logic [BUCKET_W-1:0] b
  );
    logic [TOTAL_W:0] d;
    d = {1'b0, a} - (TOTAL_W+1)'(b);
    return d[TOTAL_W] ? '0 : d[TOTAL_W-1:0];
  endfunction

  // Registers
  state_t              state, state_next;
  in_item_t            item, item_next;
  logic [TIME_W-1:0]   last_sec, last_sec_next;
  logic [SLOT_W-1:0]   last_slot, last_slot_next;
  logic [TOTAL_W-1:0]  total, total_next;
  logic [SLOT_W-1:0]   gap, gap_next;
  logic [SLOT_W-1:0]   target, target_next;
  logic [SLOT_W-1:0]   walk, walk_next;
  logic [STEP_W-1:0]   step, step_next;
  logic [SLOT_W-1:0]   rem, rem_next;
  logic [TIME_W-1:0]   quot, quot_next;
  logic [SLOT_W:0]     rem_wide, rem_wide_next;
  logic                rej, rej_next;
  logic                out_valid_next;
  out_item_t           out_item_next;

  // RAM port
  logic                ram_we, ram_re;
  logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
  logic [BUCKET_W-1:0] ram_wdata, ram_rdata;

  // Combinational helpers
  logic                accept, out_free;
  logic [BUCKET_W:0]   grown;
  logic [BUCKET_W-1:0] same_bucket, same_delta;
  logic [TIME_W:0]     diff;
  logic                gap_small;
  logic [SLOT_W:0]     tgt_sum;
  logic [SLOT_W-1:0]   tgt_slot, first_skip;
  logic                step_in_ring;
  logic [2*TIME_W-1:0] recip_prod;
  logic [TIME_W-1:0]   quot_prod, rem_diff;

  swec_ram #(
    .WIDTH (BUCKET_W),
    .DEPTH (NUM_BUCKETS)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Same-second update: saturate bucket, total grows by what the bucket grew
  assign grown       = {1'b0, ram_rdata} + (BUCKET_W+1)'(item.add_count);
  assign same_bucket = grown[BUCKET_W] ? '1 : grown[BUCKET_W-1:0];
  assign same_delta  = grown[BUCKET_W] ? ~ram_rdata : BUCKET_W'(item.add_count);

  // Time step classification
  assign diff      = {1'b0, item.time_sec} - {1'b0, last_sec};
  assign gap_small = diff[TIME_W-1:0] < TIME_N;

  // Target slot and first skipped slot, modulo the ring size
  assign tgt_sum    = {1'b0, last_slot} + {1'b0, gap};
  assign tgt_slot   = (tgt_sum >= SLOT_N) ? SLOT_W'(tgt_sum - SLOT_N) : tgt_sum[SLOT_W-1:0];
  assign first_skip = (last_slot == SLOT_LAST) ? '0 : last_slot + 1'b1;

  // Sweep: zero the ring; time modulo ring size by reciprocal multiplication,
  // the quotient estimate is at most one low so one correction suffices
  assign step_in_ring = {1'b0, step} < STEP_N;
  assign recip_prod   = {{TIME_W{1'b0}}, item.time_sec} * {{TIME_W{1'b0}}, RECIP};
  assign quot_prod    = quot * TIME_N;
  assign rem_diff     = item.time_sec - quot_prod;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (step == STEP_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (in_item.time_sec == last_sec) ? ST_SAME : ST_CLASS;
        end
      end
      ST_SAME: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLASS: begin
        if (diff[TIME_W]) begin
          state_next = ST_DONE;
        end else if (gap_small) begin
          state_next = ST_PLAN;
        end else begin
          state_next = ST_CLEAR;
        end
      end
      ST_PLAN: begin
        state_next = (first_skip == tgt_slot) ? ST_TGT : ST_SKIP;
      end
      ST_SKIP: begin
        if (walk_next == target) begin
          state_next = ST_TGT;
        end
      end
      ST_TGT:   state_next = ST_ADD;
      ST_ADD:   state_next = ST_DONE;
      ST_CLEAR: begin
        if (step == STEP_LAST) begin
          state_next = ST_PUT;
        end
      end
      ST_PUT:   state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_INIT;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
  end

  // Datapath and RAM control
  always_comb begin
    item_next      = item;
    last_sec_next  = last_sec;
    last_slot_next = last_slot;
    total_next     = total;
    gap_next       = gap;
    target_next    = target;
    walk_next      = walk;
    step_next      = step;
    rem_next       = rem;
    quot_next      = quot;
    rem_wide_next  = rem_wide;
    rej_next       = rej;
    out_valid_next = out_valid && !out_ready;
    out_item_next  = out_item;
    ram_we         = 1'b0;
    ram_waddr      = last_slot;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = last_slot;

    case (state)
      ST_INIT: begin
        ram_we    = step_in_ring;
        ram_waddr = step[SLOT_W-1:0];
        step_next = (step == STEP_LAST) ? '0 : step + 1'b1;
      end
      ST_IDLE: begin
        // Read the current bucket at once: used when the second is unchanged
        if (accept) begin
          item_next = in_item;
          ram_re    = 1'b1;
          ram_raddr = last_slot;
        end
      end
      ST_SAME: begin
        if (out_free) begin
          ram_we                     = 1'b1;
          ram_waddr                  = last_slot;
          ram_wdata                  = same_bucket;
          total_next                 = total_add(total, same_delta);
          out_valid_next             = 1'b1;
          out_item_next.window_total = total_add(total, same_delta);
          out_item_next.rejected     = 1'b0;
        end
      end
      ST_CLASS: begin
        rej_next  = diff[TIME_W];
        gap_next  = diff[SLOT_W-1:0];
        step_next = '0;
        rem_next  = '0;
      end
      ST_PLAN: begin
        target_next = tgt_slot;
        walk_next   = first_skip;
        ram_re      = 1'b1;
        ram_raddr   = first_skip;
      end
      ST_SKIP: begin
        // Drop one skipped bucket from the total and zero it
        ram_we     = 1'b1;
        ram_waddr  = walk;
        ram_wdata  = '0;
        total_next = total_sub(total, ram_rdata);
        walk_next  = (walk == SLOT_LAST) ? '0 : walk + 1'b1;
        ram_re     = 1'b1;
        ram_raddr  = walk_next;
      end
      ST_TGT: begin
        ram_we     = 1'b1;
        ram_waddr  = target;
        ram_wdata  = BUCKET_W'(item.add_count);
        total_next = total_sub(total, ram_rdata);
      end
      ST_ADD: begin
        total_next     = total_add(total, BUCKET_W'(item.add_count));
        last_sec_next  = item.time_sec;
        last_slot_next = target;
      end
      ST_CLEAR: begin
        ram_we    = step_in_ring;
        ram_waddr = step[SLOT_W-1:0];
        // Quotient estimate, remainder estimate, then final correction
        if (step == '0) begin
          quot_next = TIME_W'(recip_prod >> RECIP_SH);
        end
        if (step == STEP_W'(1)) begin
          rem_wide_next = rem_diff[SLOT_W:0];
        end
        if (step == STEP_W'(2)) begin
          rem_next = (rem_wide >= SLOT_N) ? SLOT_W'(rem_wide - SLOT_N)
                                          : rem_wide[SLOT_W-1:0];
        end
        step_next = (step == STEP_LAST) ? '0 : step + 1'b1;
      end
      ST_PUT: begin
        ram_we         = 1'b1;
        ram_waddr      = rem;
        ram_wdata      = BUCKET_W'(item.add_count);
        total_next     = TOTAL_W'(item.add_count);
        last_sec_next  = item.time_sec;
        last_slot_next = rem;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_next             = 1'b1;
          out_item_next.window_total = total;
          out_item_next.rejected     = rej;
        end
      end
      default: begin
        step_next = '0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      step      <= '0;
      last_sec  <= '0;
      last_slot <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      last_sec  <= last_sec_next;
      last_slot <= last_slot_next;
      total     <= total_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk) begin
    item     <= item_next;
    gap      <= gap_next;
    target   <= target_next;
    walk     <= walk_next;
    rem      <= rem_next;
    quot     <= quot_next;
    rem_wide <= rem_wide_next;
    rej      <= rej_next;
    out_item <= out_item_next;
  end

endmodule
